// File: rtl/core/asts_pkg.sv
`default_nettype none
package asts_pkg;

    localparam logic [1:0] KIND_BEGIN = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_SKIP  = 2'd2;

    localparam logic [1:0] END_NONE   = 2'd0;
    localparam logic [1:0] END_SKIP   = 2'd1;
    localparam logic [1:0] END_ATMAX  = 2'd2;
    localparam logic [1:0] END_MINMAX = 2'd3;

    localparam logic [3:0] BAND_RESET = 4'd3;

    localparam logic [2:0] REG_ACTORS = 3'd0;
    localparam logic [2:0] REG_HEATER = 3'd1;
    localparam logic [2:0] REG_SOAP   = 3'd2;
    localparam logic [2:0] REG_CLEAR  = 3'd3;
    localparam logic [2:0] REG_BAND   = 3'd4;

    // classified item as held in the queue
    typedef struct packed {
        logic        is_begin;
        logic        is_tick;
        logic        is_skip;
        logic [31:0] now;
        logic [9:0]  temp;
        logic [63:0] line;
        logic [7:0]  cyc;
        logic [31:0] end_min;
        logic [31:0] end_max;
        logic [9:0]  temp_floor;
        logic [9:0]  temp_ceil;
        logic [15:0] at_min;
        logic [15:0] at_max;
    } cmd_t;

    typedef struct packed {
        logic [63:0] drive_mask;
        logic        step_done;
        logic [1:0]  end_reason;
        logic        heater_on;
        logic        temp_reached;
        logic        over_temp_warning;
        logic [7:0]  cycle_count;
        logic [7:0]  step_count;
        logic        soap_dispensed;
    } res_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/appliance_step_thermostat_sequencer.sv
// Channel | Dir | Ports                  | Word
// s_      | in  | tvalid tready tdata    | item: kind, time, temp, step fields
// m_      | out | tvalid tready tdata    | result: drive mask, status, counters
// cfg     | in  | APB psel..prdata       | five registers at 8*i
//
// One item per cycle sustained while the m_ side is not stalled. An accepted item waits in
// the queue, then moves into the back end's result register, which drives m_tvalid.
// aresetn is synchronous, active low; it clears queue, step state and registers, and loads band with 3.
// A stalled m_ side fills the two-entry queue, then drops s_tready.
`default_nettype none
module appliance_step_thermostat_sequencer (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // kind[1:0], now_seconds[33:2], temperature[43:34], line_mask[107:44],
    // cycle_id[115:108], dwell_min[131:116], dwell_max[147:132], temp_floor[157:148],
    // temp_ceil[167:158], hold_min[183:168], hold_max[199:184]
    input  wire logic [199:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // drive_mask[63:0], step_done[64], end_reason[66:65], heater_on[67],
    // temp_reached[68], over_temp_warning[69], cycle_count[77:70],
    // step_count[85:78], soap_dispensed[86]
    output logic [87:0]       m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    import asts_pkg::*;

    logic [63:0] act_reg, heat_reg, soap_reg, clr_reg;
    logic [3:0]  band_reg;
    logic        q_valid, q_ready;
    cmd_t        q_cmd;
    res_t        res;
    logic [2:0]  idx;

    assign pready = 1'b1;
    assign idx    = paddr[5:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 64'd0; heat_reg <= 64'd0; soap_reg <= 64'd0;
            clr_reg <= 64'd0; band_reg <= BAND_RESET;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_ACTORS: act_reg  <= pwdata;
                REG_HEATER: heat_reg <= pwdata;
                REG_SOAP:   soap_reg <= pwdata;
                REG_CLEAR:  clr_reg  <= pwdata;
                REG_BAND:   band_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ACTORS: prdata = act_reg;
            REG_HEATER: prdata = heat_reg;
            REG_SOAP:   prdata = soap_reg;
            REG_CLEAR:  prdata = clr_reg;
            REG_BAND:   prdata = {60'd0, band_reg};
            default:    prdata = 64'd0;
        endcase
    end

    asts_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .kind(s_tdata[1:0]), .now_seconds(s_tdata[33:2]),
        .temperature(s_tdata[43:34]), .line_mask(s_tdata[107:44]),
        .cycle_id(s_tdata[115:108]), .dwell_min(s_tdata[131:116]),
        .dwell_max(s_tdata[147:132]), .temp_floor(s_tdata[157:148]),
        .temp_ceil(s_tdata[167:158]), .hold_min(s_tdata[183:168]),
        .hold_max(s_tdata[199:184]),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    asts_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .actors_mask(act_reg), .heater_mask(heat_reg), .soap_mask(soap_reg),
        .clear_mask(clr_reg), .band(band_reg),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {1'b0, res.soap_dispensed, res.step_count, res.cycle_count,
                      res.over_temp_warning, res.temp_reached, res.heater_on,
                      res.end_reason, res.step_done, res.drive_mask};
endmodule
`default_nettype wire

// File: rtl/core/asts_front.sv
`default_nettype none
module asts_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    kind,
    input  wire logic [31:0]   now_seconds,
    input  wire logic [9:0]    temperature,
    input  wire logic [63:0]   line_mask,
    input  wire logic [7:0]    cycle_id,
    input  wire logic [15:0]   dwell_min,
    input  wire logic [15:0]   dwell_max,
    input  wire logic [9:0]    temp_floor,
    input  wire logic [9:0]    temp_ceil,
    input  wire logic [15:0]   hold_min,
    input  wire logic [15:0]   hold_max,
    output logic               q_valid,
    input  wire logic          q_ready,
    output asts_pkg::cmd_t     q_cmd
);
    import asts_pkg::*;

    // two-entry queue
    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    cmd_t       c;
    logic       push, pop;
    logic [15:0] tmax;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        tmax = (dwell_max == 16'd0) ? dwell_min : dwell_max;
        c.is_begin   = (kind == KIND_BEGIN);
        c.is_tick    = (kind == KIND_TICK);
        c.is_skip    = (kind == KIND_SKIP);
        c.now        = now_seconds;
        c.temp       = temperature;
        c.line       = line_mask;
        c.cyc        = cycle_id;
        c.end_min    = sat_add(now_seconds, dwell_min);
        c.end_max    = sat_add(now_seconds, tmax);
        c.temp_floor = temp_floor;
        c.temp_ceil  = temp_ceil;
        c.at_min     = hold_min;
        c.at_max     = hold_max;
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= c;
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/asts_back.sv
`default_nettype none
module asts_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  asts_pkg::cmd_t     q_cmd,
    input  wire logic [63:0]   actors_mask,
    input  wire logic [63:0]   heater_mask,
    input  wire logic [63:0]   soap_mask,
    input  wire logic [63:0]   clear_mask,
    input  wire logic [3:0]    band,
    output logic               out_valid,
    input  wire logic          out_ready,
    output asts_pkg::res_t     out_res
);
    import asts_pkg::*;

    logic        active_reg, heat_reg, begun_reg, warned_reg, lcv_reg, soap_reg;
    logic [31:0] emin_reg, emax_reg;
    logic [63:0] req_reg, drive_reg;
    logic [9:0]  lo_reg, hi_reg;
    logic [15:0] atmin_reg, atmax_reg;
    logic [7:0]  lcyc_reg, cyc_reg, stp_reg;
    logic        ov_reg;
    res_t        res_reg;

    logic        active_next, heat_next, begun_next, warned_next, lcv_next, soap_next;
    logic [31:0] emin_next, emax_next, e;
    logic [63:0] req_next, drive_next, actors;
    logic [9:0]  lo_next, hi_next;
    logic [15:0] atmin_next, atmax_next;
    logic [7:0]  lcyc_next, cyc_next, stp_next;
    logic        done, warn, cooled, want, go;
    logic [1:0]  reason;
    logic [10:0] hdiff;

    assign q_ready   = !ov_reg || out_ready;
    assign go        = q_valid && q_ready;
    assign out_valid = ov_reg;
    assign out_res   = res_reg;

    always_comb begin
        active_next = active_reg; heat_next = heat_reg; begun_next = begun_reg;
        warned_next = warned_reg; lcv_next = lcv_reg; soap_next = soap_reg;
        emin_next = emin_reg; emax_next = emax_reg; req_next = req_reg;
        drive_next = drive_reg; lo_next = lo_reg; hi_next = hi_reg;
        atmin_next = atmin_reg; atmax_next = atmax_reg; lcyc_next = lcyc_reg;
        cyc_next = cyc_reg; stp_next = stp_reg;
        done = 1'b0; reason = END_NONE; warn = 1'b0; want = 1'b0;
        e = 32'd0;
        actors = req_reg & actors_mask & ~heater_mask;
        // borrow out means the ceiling sits below the band
        hdiff  = {1'b0, hi_reg} - {7'd0, band};
        cooled = !hdiff[10] && (q_cmd.temp <= hdiff[9:0]);
        if (q_cmd.is_begin) begin
            if (active_reg) begin
                if (heat_reg) drive_next = drive_next & ~heater_mask;
                drive_next = drive_next & ~actors;
            end
            stp_next = stp_reg + 8'd1;
            if (!lcv_reg || q_cmd.cyc != lcyc_reg) begin
                cyc_next = cyc_reg + 8'd1;
                lcyc_next = q_cmd.cyc;
                lcv_next = 1'b1;
            end
            if ((q_cmd.line & soap_mask) != 64'd0) soap_next = 1'b1;
            req_next = q_cmd.line;
            lo_next = q_cmd.temp_floor; hi_next = q_cmd.temp_ceil;
            atmin_next = q_cmd.at_min; atmax_next = q_cmd.at_max;
            emin_next = q_cmd.end_min; emax_next = q_cmd.end_max;
            heat_next = 1'b0; begun_next = 1'b0; warned_next = 1'b0;
            drive_next = (drive_next & ~clear_mask)
                       | (q_cmd.line & actors_mask & ~heater_mask);
            active_next = 1'b1;
        end else if (q_cmd.is_skip) begin
            if (active_reg) begin
                if (heat_reg) drive_next = drive_next & ~heater_mask;
                drive_next = drive_next & ~actors;
                heat_next = 1'b0; active_next = 1'b0;
                done = 1'b1; reason = END_SKIP;
            end
        end else if (q_cmd.is_tick && active_reg) begin
            if (lo_reg != 10'd0 || hi_reg != 10'd0) begin
                if (!begun_reg && lo_reg != 10'd0 && q_cmd.temp >= lo_reg) begin
                    begun_next = 1'b1;
                    if (atmin_reg != 16'd0) begin
                        e = sat_add(q_cmd.now, atmin_reg);
                        if (e > emin_reg) emin_next = e;
                    end
                    if (atmax_reg != 16'd0) emax_next = sat_add(q_cmd.now, atmax_reg);
                end
                if (hi_reg != 10'd0) begin
                    if (!warned_reg && q_cmd.temp > hi_reg) begin
                        warned_next = 1'b1; warn = 1'b1;
                    end else if (warned_reg && cooled) begin
                        warned_next = 1'b0;
                    end
                    if ((req_reg & heater_mask) != 64'd0)
                        want = heat_reg ? (q_cmd.temp < hi_reg) : cooled;
                    if (want && !heat_reg) begin
                        drive_next = drive_next | heater_mask; heat_next = 1'b1;
                    end else if (!want && heat_reg) begin
                        drive_next = drive_next & ~heater_mask; heat_next = 1'b0;
                    end
                end
            end else if (heat_reg) begin
                drive_next = drive_next & ~heater_mask; heat_next = 1'b0;
            end
            drive_next = drive_next | actors;
            if (q_cmd.now >= emax_next && (q_cmd.now >= emin_next || atmax_reg != 16'd0)) begin
                reason = (atmax_reg != 16'd0) ? END_ATMAX : END_MINMAX;
                done = 1'b1;
                if (heat_next) drive_next = drive_next & ~heater_mask;
                drive_next = drive_next & ~actors;
                heat_next = 1'b0; active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            res_reg.drive_mask <= drive_next;
            res_reg.step_done <= done;
            res_reg.end_reason <= reason;
            res_reg.heater_on <= heat_next;
            res_reg.temp_reached <= begun_next;
            res_reg.over_temp_warning <= warn;
            res_reg.cycle_count <= cyc_next;
            res_reg.step_count <= stp_next;
            res_reg.soap_dispensed <= soap_next;
        end
        if (!aresetn) begin
            ov_reg <= 1'b0;
            active_reg <= 1'b0; heat_reg <= 1'b0; begun_reg <= 1'b0;
            warned_reg <= 1'b0; lcv_reg <= 1'b0; soap_reg <= 1'b0;
            emin_reg <= 32'd0; emax_reg <= 32'd0; req_reg <= 64'd0;
            drive_reg <= 64'd0; lo_reg <= 10'd0; hi_reg <= 10'd0;
            atmin_reg <= 16'd0; atmax_reg <= 16'd0; lcyc_reg <= 8'd0;
            cyc_reg <= 8'd0; stp_reg <= 8'd0;
        end else begin
            if (go) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
            if (go) begin
                active_reg <= active_next; heat_reg <= heat_next;
                begun_reg <= begun_next; warned_reg <= warned_next;
                lcv_reg <= lcv_next; soap_reg <= soap_next;
                emin_reg <= emin_next; emax_reg <= emax_next; req_reg <= req_next;
                drive_reg <= drive_next; lo_reg <= lo_next; hi_reg <= hi_next;
                atmin_reg <= atmin_next; atmax_reg <= atmax_next;
                lcyc_reg <= lcyc_next; cyc_reg <= cyc_next; stp_reg <= stp_next;
            end
        end
    end
endmodule
`default_nettype wire
